// ===== rtl/tacf_pkg.sv =====
package tacf_pkg;

    localparam int DATA_W = 16;
    localparam int REG_W  = 15;
    localparam int CFG_ADDR_W = 2;

    // Width of the error term accel - angle + remainder.
    localparam int ERR_W  = DATA_W + 2;
    // Width of the final sum before saturation.
    localparam int SUM_W  = DATA_W + 3;
    localparam int PROD_W = DATA_W + REG_W;
    localparam int DVD_W  = 32;
    localparam int QUO_W  = ERR_W - 1;

    localparam logic [REG_W-1:0] GYRO_DIVISOR = 15'd30000;
    localparam logic [REG_W-1:0] GAIN_RESET   = 15'd139;
    localparam logic [REG_W-1:0] TC_RESET     = 15'd400;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TC   = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_res;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
        logic [REG_W-1:0] rem;
    } t_div_res;

endpackage

// ===== rtl/tilt_angle_complementary_filter.sv =====
// Fuses an accelerometer tilt angle with a gyro rate into a running angle
// estimate. Each input transaction carries accel_angle in tdata[15:0] and
// gyro_rate in tdata[31:16]; each produces exactly one output transaction
// with the new saturated angle in tdata[15:0]. The block works on one sample
// at a time and steps through accepting it, the two-bit-per-cycle multiplier
// for gyro_rate * gyro_gain, handing the product on, the two-bit-per-cycle
// dividers (the gyro product by 30000 and the correction error by
// time_constant, side by side), handing the quotients on, and adding and
// saturating. The next sample is taken while a finished result still waits
// on the output; a result that finds the output register still full holds
// the block in its last step until the register drains.
// Registers (gyro_gain at index 0, time_constant at index 1, reset values 139
// and 400; writes to other indexes are ignored) are to be written only while
// idle; a time_constant of zero acts as one.
module tilt_angle_complementary_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tacf_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tacf_pkg::REG_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0 up: accel_angle[15:0], gyro_rate[31:16].
    input  logic [2*tacf_pkg::DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0 up: fused_angle[15:0].
    output logic [tacf_pkg::DATA_W-1:0]       o_m_axis_tdata
);

    tacf_pkg::t_state                  r_state;
    tacf_pkg::t_state                  n_state;
    logic [tacf_pkg::REG_W-1:0]        r_gain;
    logic [tacf_pkg::REG_W-1:0]        r_tc;
    logic signed [tacf_pkg::DATA_W-1:0] r_angle;
    logic signed [tacf_pkg::DATA_W-1:0] r_rem;
    logic signed [tacf_pkg::DATA_W-1:0] r_accel;
    logic                              r_gyro_neg;
    logic                              r_err_neg;
    logic                              r_out_valid;
    logic [tacf_pkg::DATA_W-1:0]       r_out_data;

    logic                              w_accept;
    logic                              w_mul_start;
    logic                              w_div_start;
    logic                              w_fin_load;
    logic signed [tacf_pkg::DATA_W-1:0] w_gyro;
    logic [tacf_pkg::DATA_W-1:0]       w_gyro_mag;
    logic signed [tacf_pkg::ERR_W-1:0] w_err;
    logic [tacf_pkg::ERR_W-2:0]        w_err_mag;
    logic [tacf_pkg::REG_W-1:0]        w_tc_eff;
    logic signed [tacf_pkg::SUM_W-1:0] w_gterm;
    logic signed [tacf_pkg::SUM_W-1:0] w_corr;
    logic signed [tacf_pkg::SUM_W-1:0] w_sum;
    logic signed [tacf_pkg::DATA_W-1:0] w_sat;
    logic signed [tacf_pkg::DATA_W-1:0] w_rem_signed;

    tacf_pkg::t_mul_res                w_mul_res;
    tacf_pkg::t_div_res                w_gdiv_res;
    tacf_pkg::t_div_res                w_ediv_res;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_gyro   = i_s_axis_tdata[2*tacf_pkg::DATA_W-1:tacf_pkg::DATA_W];
    assign w_gyro_mag = w_gyro[tacf_pkg::DATA_W-1] ? (~w_gyro + 16'd1) : w_gyro;

    // ---- state machine ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            tacf_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = tacf_pkg::S_MUL;
                end
            end
            tacf_pkg::S_MUL: begin
                if (w_mul_res.done) begin
                    n_state = tacf_pkg::S_DIV;
                end
            end
            tacf_pkg::S_DIV: begin
                if (w_gdiv_res.done && w_ediv_res.done) begin
                    n_state = tacf_pkg::S_FIN;
                end
            end
            tacf_pkg::S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = tacf_pkg::S_IDLE;
                end
            end
            default: n_state = tacf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_fin_load      = 1'b0;
        case (r_state)
            tacf_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            tacf_pkg::S_MUL:  w_div_start = w_mul_res.done;
            tacf_pkg::S_DIV:  ;
            tacf_pkg::S_FIN:  w_fin_load = !r_out_valid || i_m_axis_tready;
            default:          ;
        endcase
    end

    assign w_mul_start = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tacf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= tacf_pkg::GAIN_RESET;
            r_tc   <= tacf_pkg::TC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tacf_pkg::CFG_GAIN: r_gain <= i_cfg_wdata;
                tacf_pkg::CFG_TC:   r_tc   <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // ---- arithmetic units ----
    tacf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_gyro_mag),
        .i_mplier (r_gain),
        .o_res    (w_mul_res)
    );

    // The correction error uses the angle and remainder left by the last sample.
    assign w_err = {{2{r_accel[tacf_pkg::DATA_W-1]}}, r_accel}
                 - {{2{r_angle[tacf_pkg::DATA_W-1]}}, r_angle}
                 + {{2{r_rem[tacf_pkg::DATA_W-1]}}, r_rem};
    assign w_err_mag = w_err[tacf_pkg::ERR_W-1]
                     ? tacf_pkg::QUO_W'(-w_err) : w_err[tacf_pkg::ERR_W-2:0];
    assign w_tc_eff  = (r_tc == '0) ? tacf_pkg::REG_W'(1) : r_tc;

    tacf_div u_gdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({{(tacf_pkg::DVD_W-tacf_pkg::PROD_W){1'b0}}, w_mul_res.prod}),
        .i_divisor  (tacf_pkg::GYRO_DIVISOR),
        .o_res      (w_gdiv_res)
    );

    tacf_div u_ediv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({{(tacf_pkg::DVD_W-tacf_pkg::QUO_W){1'b0}}, w_err_mag}),
        .i_divisor  (w_tc_eff),
        .o_res      (w_ediv_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_accel    <= i_s_axis_tdata[tacf_pkg::DATA_W-1:0];
            r_gyro_neg <= w_gyro[tacf_pkg::DATA_W-1];
        end
        if (w_div_start) begin
            r_err_neg <= w_err[tacf_pkg::ERR_W-1];
        end
    end

    // ---- combine and saturate ----
    always_comb begin
        w_gterm = r_gyro_neg ? -$signed({2'b00, w_gdiv_res.quo})
                             :  $signed({2'b00, w_gdiv_res.quo});
        w_corr  = r_err_neg  ? -$signed({2'b00, w_ediv_res.quo})
                             :  $signed({2'b00, w_ediv_res.quo});
        w_sum   = {{3{r_angle[tacf_pkg::DATA_W-1]}}, r_angle} + w_gterm + w_corr;
        if (w_sum > $signed(tacf_pkg::SUM_W'(32767))) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -$signed(tacf_pkg::SUM_W'(32768))) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[tacf_pkg::DATA_W-1:0];
        end
        w_rem_signed = r_err_neg ? -$signed({1'b0, w_ediv_res.rem})
                                 :  $signed({1'b0, w_ediv_res.rem});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_rem   <= '0;
        end else if (w_fin_load) begin
            r_angle <= w_sat;
            r_rem   <= w_rem_signed;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_data <= w_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/tacf_mul.sv =====
module tacf_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tacf_pkg::DATA_W-1:0]       i_mcand,
    input  logic [tacf_pkg::REG_W-1:0]        i_mplier,
    output tacf_pkg::t_mul_res                o_res
);

    logic                              r_busy;
    logic [2:0]                        r_cnt;
    logic                              r_done;
    logic [tacf_pkg::DATA_W-1:0]       r_mp;
    logic [tacf_pkg::DATA_W-1:0]       r_m1;
    logic [tacf_pkg::DATA_W+1:0]       r_m3;
    logic [tacf_pkg::PROD_W-1:0]       r_acc;
    logic [tacf_pkg::PROD_W-1:0]       n_acc;
    logic [tacf_pkg::DATA_W+1:0]       w_digit_val;

    // The multiplier is consumed two bits per cycle, most significant digit first.
    always_comb begin
        case (r_mp[tacf_pkg::DATA_W-1 -: 2])
            2'd0:    w_digit_val = '0;
            2'd1:    w_digit_val = {2'b00, r_m1};
            2'd2:    w_digit_val = {1'b0, r_m1, 1'b0};
            2'd3:    w_digit_val = r_m3;
            default: w_digit_val = '0;
        endcase
        n_acc = {r_acc[tacf_pkg::PROD_W-3:0], 2'b00}
              + {{(tacf_pkg::PROD_W-tacf_pkg::DATA_W-2){1'b0}}, w_digit_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 3'd7);
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mp  <= {1'b0, i_mplier};
            r_m1  <= i_mcand;
            r_m3  <= {2'b00, i_mcand} + {1'b0, i_mcand, 1'b0};
            r_acc <= '0;
        end else if (r_busy) begin
            r_mp  <= {r_mp[tacf_pkg::DATA_W-3:0], 2'b00};
            r_acc <= n_acc;
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_acc;

endmodule

// ===== rtl/tacf_div.sv =====
module tacf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tacf_pkg::DVD_W-1:0]        i_dividend,
    input  logic [tacf_pkg::REG_W-1:0]        i_divisor,
    output tacf_pkg::t_div_res                o_res
);

    logic                              r_busy;
    logic [3:0]                        r_cnt;
    logic                              r_done;
    logic [tacf_pkg::DVD_W-1:0]        r_q;
    logic [tacf_pkg::REG_W-1:0]        r_r;
    logic [tacf_pkg::REG_W-1:0]        r_d;
    logic [tacf_pkg::DVD_W-1:0]        n_q;
    logic [tacf_pkg::REG_W-1:0]        n_r;

    // Two restoring steps per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    always_comb begin
        logic [tacf_pkg::REG_W:0] t;
        n_q = r_q;
        n_r = r_r;
        for (int i = 0; i < 2; i++) begin
            t = {n_r, n_q[tacf_pkg::DVD_W-1]};
            if (t >= {1'b0, r_d}) begin
                t = t - {1'b0, r_d};
                n_q = {n_q[tacf_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_q = {n_q[tacf_pkg::DVD_W-2:0], 1'b0};
            end
            n_r = t[tacf_pkg::REG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 4'd15);
            if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_q[tacf_pkg::QUO_W-1:0];
    assign o_res.rem  = r_r;

endmodule

// ===== rtl/tacf_chk.sv =====
module tacf_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [tacf_pkg::DATA_W-1:0]       o_m_axis_tdata
);

    // A result waiting on the output holds its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output result changed or dropped while stalled");

    // Once a sample is taken, the block is busy with it on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second sample accepted while one is in work");

    // A new result cannot appear right after a sample is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared too early after a transaction");

    // Reset empties the output and makes the block ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset did not clear the block");

endmodule

bind tilt_angle_complementary_filter tacf_chk u_tacf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/tacf_fusion_checker.sv =====
module tacf_fusion_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tacf_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tacf_pkg::REG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    // Fields from bit 0 up: accel_angle[15:0], gyro_rate[31:16].
    input  logic [2*tacf_pkg::DATA_W-1:0]       i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    // Fields from bit 0 up: fused_angle[15:0].
    input  logic [tacf_pkg::DATA_W-1:0]         i_out_data,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [tacf_pkg::REG_W-1:0]         gain_reg;
    logic [tacf_pkg::REG_W-1:0]         tc_reg;
    logic signed [tacf_pkg::DATA_W-1:0] angle_est;
    logic signed [tacf_pkg::DATA_W-1:0] err_rem;
    logic [tacf_pkg::DATA_W-1:0]        expected_angles[$];
    int                                 checked_cnt;
    int                                 fail_cnt;

    // Advances the filter state by one sample and returns the new angle.
    function automatic logic [tacf_pkg::DATA_W-1:0] fuse_sample(
        input logic signed [tacf_pkg::DATA_W-1:0] accel,
        input logic signed [tacf_pkg::DATA_W-1:0] gyro);
        longint divisor;
        longint gyro_term;
        longint err;
        longint corr;
        longint rem;
        longint sum;
        // A zero time constant behaves as one.
        divisor   = (tc_reg == '0) ? 64'sd1 : longint'(tc_reg);
        gyro_term = (longint'(gyro) * longint'(gain_reg))
                  / longint'(tacf_pkg::GYRO_DIVISOR);
        err       = longint'(accel) - longint'(angle_est) + longint'(err_rem);
        corr      = err / divisor;
        rem       = err % divisor;
        sum       = longint'(angle_est) + gyro_term + corr;
        if (sum > 32767) begin
            sum = 32767;
        end else if (sum < -32768) begin
            sum = -32768;
        end
        // The remainder comes from the division alone; saturation does not touch it.
        angle_est = sum[tacf_pkg::DATA_W-1:0];
        err_rem   = rem[tacf_pkg::DATA_W-1:0];
        return angle_est;
    endfunction

    always @(posedge i_clk) begin
        logic [tacf_pkg::DATA_W-1:0] want;
        if (!i_rst_n) begin
            gain_reg  = tacf_pkg::GAIN_RESET;
            tc_reg    = tacf_pkg::TC_RESET;
            angle_est = '0;
            err_rem   = '0;
            expected_angles.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_angles.size() == 0) begin
                    $error("fused_angle transaction with no sample waiting: actual %0d",
                           $signed(i_out_data));
                    fail_cnt++;
                end else begin
                    want = expected_angles.pop_front();
                    checked_cnt++;
                    if (i_out_data !== want) begin
                        $error("fused_angle mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(i_out_data));
                        fail_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == tacf_pkg::CFG_GAIN) begin
                    gain_reg = i_cfg_wdata;
                end else if (i_cfg_addr == tacf_pkg::CFG_TC) begin
                    tc_reg = i_cfg_wdata;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_angles.push_back(
                    fuse_sample(i_in_data[tacf_pkg::DATA_W-1:0],
                                i_in_data[2*tacf_pkg::DATA_W-1:tacf_pkg::DATA_W]));
            end
        end
        o_pending  <= expected_angles.size();
        o_checked  <= checked_cnt;
        o_failures <= fail_cnt;
    end

endmodule

// ===== sim/tilt_angle_complementary_filter_test.sv =====
module tilt_angle_complementary_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int BLOCK_LATENCY  = 32;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 125;
    localparam int LONG_HOLD      = 400;
    localparam logic [tacf_pkg::DATA_W-1:0] MAX_S = 16'h7FFF;
    localparam logic [tacf_pkg::DATA_W-1:0] MIN_S = 16'h8000;
    // An index that maps to no register.
    localparam logic [tacf_pkg::CFG_ADDR_W-1:0] CFG_NONE = 2'd2;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [tacf_pkg::CFG_ADDR_W-1:0]     i_cfg_addr = tacf_pkg::CFG_GAIN;
    logic [tacf_pkg::REG_W-1:0]          i_cfg_wdata = '0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    // Fields from bit 0 up: accel_angle[15:0], gyro_rate[31:16].
    logic [2*tacf_pkg::DATA_W-1:0]       i_s_axis_tdata = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    // Fields from bit 0 up: fused_angle[15:0].
    logic [tacf_pkg::DATA_W-1:0]         o_m_axis_tdata;

    int pending;
    int checked;
    int failures;
    int cycle_cnt = 0;
    int sample_cnt = 0;
    int setting_cnt = 0;
    bit steady = 1'b0;
    int long_hold_reqs = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tilt_angle_complementary_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    tacf_fusion_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_ready  (o_s_axis_tready),
        .i_in_data   (i_s_axis_tdata),
        .i_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_out_data  (o_m_axis_tdata),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_failures  (failures)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (steady || sel < 60) begin
            return 0;
        end else if (sel < 90) begin
            return $urandom_range(1, 3);
        end else if (sel < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [tacf_pkg::DATA_W-1:0] pick_field();
        int sel;
        logic [tacf_pkg::DATA_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            v = tacf_pkg::DATA_W'($urandom);
        end else if (sel < 9) begin
            // Small values keep the estimate away from the rails.
            v = tacf_pkg::DATA_W'($urandom_range(0, 400));
            v = v - 16'd200;
        end else begin
            v = $urandom_range(0, 1) ? MAX_S : MIN_S;
        end
        return v;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction took place.
    task automatic send_sample(input logic [tacf_pkg::DATA_W-1:0] accel,
                               input logic [tacf_pkg::DATA_W-1:0] gyro);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {gyro, accel};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sample_cnt++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tacf_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [tacf_pkg::REG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [tacf_pkg::REG_W-1:0] gain,
                              input logic [tacf_pkg::REG_W-1:0] tc);
        drain();
        write_reg(tacf_pkg::CFG_GAIN, gain);
        write_reg(tacf_pkg::CFG_TC, tc);
        setting_cnt++;
    endtask

    // Output side: random back-pressure, plus one long hold when asked.
    initial begin
        int hold;
        int holds_seen;
        hold = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_reqs != holds_seen) begin
                hold = LONG_HOLD;
                holds_seen = long_hold_reqs;
            end
            if (hold > 0) begin
                i_m_axis_tready <= 1'b0;
                hold--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: field extremes and alternating bit patterns.
        send_sample(16'd0, 16'd0);
        send_sample(MAX_S, 16'd0);
        send_sample(MIN_S, 16'd0);
        send_sample(16'd0, MAX_S);
        send_sample(16'd0, MIN_S);
        send_sample(MAX_S, MAX_S);
        send_sample(MIN_S, MIN_S);
        send_sample(16'h5555, 16'hAAAA);

        // Full gain and the smallest divisor drive the angle into both rails.
        set_config(15'h7FFF, 15'd1);
        send_sample(16'd0, MAX_S);
        send_sample(16'd0, MAX_S);
        send_sample(MIN_S, MIN_S);
        send_sample(MIN_S, MIN_S);
        send_sample(MIN_S, MIN_S);
        send_sample(MAX_S, MIN_S);

        // A zero time constant takes the whole error as correction. A write to an
        // index with no register behind it must leave both settings alone.
        set_config(15'd30000, 15'd0);
        write_reg(CFG_NONE, 15'h1234);
        send_sample(16'd100, 16'hFFFF);
        send_sample(MIN_S, MAX_S);
        send_sample(MAX_S, 16'd0);

        // The largest divisor keeps a large remainder from sample to sample.
        set_config(15'd0, 15'h7FFF);
        repeat (3) send_sample(MAX_S, 16'd0);
        repeat (3) send_sample(MIN_S, 16'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_config(tacf_pkg::GAIN_RESET, tacf_pkg::TC_RESET);
                1: set_config(tacf_pkg::REG_W'($urandom_range(0, 32767)),
                              tacf_pkg::REG_W'($urandom_range(1, 32767)));
                2: set_config(tacf_pkg::REG_W'($urandom_range(0, 32767)),
                              tacf_pkg::REG_W'($urandom_range(0, 16)));
                3: set_config(15'h7FFF, 15'h7FFF);
                4: set_config(15'd0, 15'd1);
                default: set_config(tacf_pkg::REG_W'($urandom_range(0, 400)),
                                    tacf_pkg::REG_W'($urandom_range(1, 1000)));
            endcase
            steady = (p == 4);
            // The output stalls for a long time while samples keep coming.
            if (p == 2) begin
                long_hold_reqs++;
            end
            repeat (PHASE_SAMPLES) send_sample(pick_field(), pick_field());
        end
        steady = 1'b0;
        drain();

        $display("Run covered %0d samples under %0d register settings after reset.",
                 sample_cnt, setting_cnt);
        $display("Checked %0d fused angles, including rail saturation and zero divisor.",
                 checked);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tacf_pkg.sv
rtl/tacf_mul.sv
rtl/tacf_div.sv
rtl/tilt_angle_complementary_filter.sv
rtl/tacf_chk.sv
sim/tacf_fusion_checker.sv
sim/tilt_angle_complementary_filter_test.sv
